>>> src/fr_pkg.sv
// Shared constants for the fraction reducer: sequencer state codes.
package fr_pkg;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TWOS  = 3'd1;
    localparam logic [2:0] ST_GCD   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_DIVN  = 3'd4;
    localparam logic [2:0] ST_DIVD  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

endpackage

>>> src/fraction_reducer.sv
// Fraction reducer: binary gcd and two restoring divisions on one shared subtractor.
//
//  channel | direction | tdata fields (lowest bit first)
//  --------+-----------+--------------------------------------------------
//  s_      | in        | numerator_in, denominator_in
//  m_      | out       | numerator_out, denominator_out, common_factor
//
//  One transaction is in work at a time; s_tready is high only while idle.
//  When either value is 0 or 1 the result goes straight out with a factor of one;
//  otherwise the k shared factors of two are stripped, the gcd steps run, the factors
//  are restored and, unless the gcd is one, both values are divided by it.
//  Reset clears the sequencer and the output valid; no clearing pass.
//  The result waits in an output register until m_tready takes it.
module fraction_reducer #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // numerator_in, denominator_in
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]         s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // numerator_out, denominator_out, common_factor
    output logic [((3*VALUE_WIDTH+7)/8)*8-1:0]         m_tdata
);
    import fr_pkg::*;

    localparam int W    = VALUE_WIDTH;
    localparam int KW   = $clog2(W);
    localparam int MW   = ((3*VALUE_WIDTH+7)/8)*8;

    logic [2:0]    state_reg, state_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  num_reg, num_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic [MW-1:0] m_data_reg, m_data_next;

    logic [W-1:0]  in_num, in_den;
    logic [W:0]    opa, opb;
    logic [W+1:0]  diff;
    logic          a_ge_b;
    logic          fits;
    logic [W:0]    div_shift;
    logic          div_last;

    assign in_num = s_tdata[W-1:0];
    assign in_den = s_tdata[2*W-1:W];
    assign a_ge_b = (a_reg >= b_reg);
    assign div_last = (cnt_reg == KW'(W-1));

    // Shared compare/subtract unit: operands chosen by the sequencer
    always_comb begin
        div_shift = {rem_reg, (state_reg == ST_DIVD) ? den_reg[W-1] : num_reg[W-1]};
        if (state_reg == ST_DIVN || state_reg == ST_DIVD) begin
            opa = div_shift;
            opb = {1'b0, a_reg};
        end else if (a_ge_b) begin
            opa = {1'b0, a_reg};
            opb = {1'b0, b_reg};
        end else begin
            opa = {1'b0, b_reg};
            opb = {1'b0, a_reg};
        end
        diff = {1'b0, opa} - {1'b0, opb};
        fits = ~diff[W+1];
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    num_next = in_num;
                    den_next = in_den;
                    a_next   = in_num;
                    b_next   = in_den;
                    k_next   = '0;
                    if (in_num <= W'(1) || in_den <= W'(1)) begin
                        a_next     = W'(1);
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_TWOS;
                    end
                end
            end
            ST_TWOS: begin
                // strip common factors of two
                if (!a_reg[0] && !b_reg[0]) begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + KW'(1);
                end else begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (a_reg == b_reg) begin
                    state_next = ST_SCALE;
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (a_ge_b) begin
                    a_next = diff[W:1];
                end else begin
                    b_next = diff[W:1];
                end
            end
            ST_SCALE: begin
                // restore the factors of two, then divide unless the gcd is one
                if (k_reg != '0) begin
                    a_next = a_reg << 1;
                    k_next = k_reg - KW'(1);
                end else if (a_reg == W'(1)) begin
                    state_next = ST_DONE;
                end else begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN: begin
                rem_next = fits ? diff[W-1:0] : div_shift[W-1:0];
                num_next = {num_reg[W-2:0], fits};
                cnt_next = cnt_reg + KW'(1);
                if (div_last) begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                rem_next = fits ? diff[W-1:0] : div_shift[W-1:0];
                den_next = {den_reg[W-2:0], fits};
                cnt_next = cnt_reg + KW'(1);
                if (div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = MW'({a_reg, den_reg, num_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // An accepted transaction takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a transaction but stayed ready");

    // The gcd loop never works on a zero operand
    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GCD) |-> (a_reg != '0 && b_reg != '0))
        else $error("zero operand in gcd loop");

    // Divisor is at least two during division
    a_div_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVN || state_reg == ST_DIVD) |-> (a_reg > W'(1)))
        else $error("division by a trivial divisor");

    // A delivered factor is never zero
    a_factor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[3*W-1:2*W] != '0))
        else $error("zero common factor");
`endif

endmodule
